// ===== design/morse_code_keyer_core_macros.svh =====
// assertion macros for the morse keyer checker
// used by mck_checker only; no other dependencies
`ifndef MORSE_CODE_KEYER_CORE_MACROS_SVH
`define MORSE_CODE_KEYER_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define MCK_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mck check failed: same-cycle implication");

// next-cycle implication, off during reset
`define MCK_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mck check failed: next-cycle implication");

// next-cycle implication, also checked through reset
`define MCK_ASSERT_NXT_RST(label, ante, cons) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("mck check failed: reset behavior");

`endif

// ===== design/mck_pkg.sv =====
// shared types, constants and the code table of the morse keyer
// no dependencies
package mck_pkg;

    localparam int TICK_W = 19;
    localparam int DOT_W  = 16;
    localparam logic [DOT_W-1:0] DOT_TICKS_RESET = 16'd100;

    // input beat
    typedef struct packed {
        logic       action;
        logic [7:0] char_code;
    } mck_in_t;

    // result beat
    typedef struct packed {
        logic lamp_on;
        logic busy_res;
        logic char_taken;
    } mck_out_t;

    // item action codes
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_OFFER = 1'b1;

    // character class found by the front end
    typedef enum logic [1:0] {
        CLS_SYMBOL = 2'd0,
        CLS_SPACE  = 2'd1,
        CLS_OTHER  = 2'd2
    } mck_cls_t;

    // classified item, queued between front and back
    typedef struct packed {
        logic       action;
        mck_cls_t   cls;
        logic [4:0] pattern;
        logic [2:0] total;
    } mck_op_t;

    // {element count, pattern}; pattern bit i set = element i is a dash
    localparam logic [7:0] CODE_TABLE [36] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},  {3'd1, 5'd0},
        {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd14},
        {3'd3, 5'd5},  {3'd4, 5'd2},  {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},
        {3'd4, 5'd6},  {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},  {3'd4, 5'd13},
        {3'd4, 5'd3},
        {3'd5, 5'd31}, {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24}, {3'd5, 5'd16},
        {3'd5, 5'd0},  {3'd5, 5'd1},  {3'd5, 5'd3},  {3'd5, 5'd7},  {3'd5, 5'd15}
    };

endpackage

// ===== design/mck_front.sv =====
// front end: takes input beats and classifies the character
// depends on mck_pkg
module mck_front (
    input  logic             s_valid,
    output logic             s_ready,
    input  mck_pkg::mck_in_t s_data,
    output logic             push,
    output mck_pkg::mck_op_t push_op,
    input  logic             q_ready
);
    import mck_pkg::*;

    logic [7:0] code;
    logic [7:0] off_upper;
    logic [7:0] off_lower;
    logic [7:0] off_digit;
    logic [5:0] idx;
    logic       mapped;
    logic [7:0] entry;

    assign code      = s_data.char_code;
    assign off_upper = code - 8'h41;
    assign off_lower = code - 8'h61;
    assign off_digit = code - 8'h30 + 8'd26;

    // table index for letters of either case and digits
    always_comb begin
        mapped = 1'b1;
        idx    = 6'd0;
        if (code >= 8'h41 && code <= 8'h5a) begin
            idx = off_upper[5:0];
        end else if (code >= 8'h61 && code <= 8'h7a) begin
            idx = off_lower[5:0];
        end else if (code >= 8'h30 && code <= 8'h39) begin
            idx = off_digit[5:0];
        end else begin
            mapped = 1'b0;
        end
    end

    assign entry = CODE_TABLE[idx];

    // build the queued operation
    always_comb begin
        push_op.action  = s_data.action;
        push_op.pattern = 5'd0;
        push_op.total   = 3'd0;
        if (mapped) begin
            push_op.cls     = CLS_SYMBOL;
            push_op.pattern = entry[4:0];
            push_op.total   = entry[7:5];
        end else if (code == 8'h20) begin
            push_op.cls = CLS_SPACE;
        end else begin
            push_op.cls = CLS_OTHER;
        end
    end

    assign s_ready = q_ready;
    assign push    = s_valid && q_ready;

endmodule

// ===== design/mck_queue.sv =====
// two-entry queue between front end and back end
// depends on mck_pkg
module mck_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  mck_pkg::mck_op_t push_op,
    output logic             q_ready,
    output logic             q_valid,
    output mck_pkg::mck_op_t q_op,
    input  logic             pop
);
    import mck_pkg::*;

    mck_op_t    mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign q_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_op    = mem_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== design/mck_back.sv =====
// back end: element timing sequencer, dot-time register and result register
// depends on mck_pkg
module mck_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              q_valid,
    input  mck_pkg::mck_op_t  q_op,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output mck_pkg::mck_out_t m_data
);
    import mck_pkg::*;

    typedef enum logic [1:0] {
        PH_ON  = 2'd0,
        PH_GAP = 2'd1,
        PH_END = 2'd2
    } phase_t;

    logic [DOT_W-1:0]  dot_reg;
    logic              running_reg, running_next;
    logic              lamp_reg, lamp_next;
    logic [4:0]        bits_reg, bits_next;
    logic [2:0]        total_reg, total_next;
    logic [2:0]        pos_reg, pos_next;
    phase_t            phase_reg, phase_next;
    logic              wgd_reg, wgd_next;
    logic [TICK_W-1:0] ticks_reg, ticks_next;
    logic              m_valid_reg;
    mck_out_t          m_data_reg, m_data_next;

    logic [TICK_W-1:0] u1, u3, u7;
    logic [TICK_W-1:0] ticks_dec;
    logic [2:0]        pos_inc;
    logic              dash_at_inc;
    logic              taken;

    // phase lengths from the dot time, kept to the tick counter width
    assign u1 = {3'b000, dot_reg};
    assign u3 = {3'b000, dot_reg} + {2'b00, dot_reg, 1'b0};
    assign u7 = {dot_reg, 3'b000} - {3'b000, dot_reg};

    assign ticks_dec = (ticks_reg != '0) ? ticks_reg - 1'b1 : ticks_reg;
    assign pos_inc   = pos_reg + 3'd1;
    assign dash_at_inc = (pos_inc < 3'd5) ? bits_reg[pos_inc] : 1'b0;

    // back end takes a beat whenever the result register can take its result
    assign pop = q_valid && (!m_valid_reg || m_ready);

    // sequencer next state
    always_comb begin
        running_next = running_reg;
        lamp_next    = lamp_reg;
        bits_next    = bits_reg;
        total_next   = total_reg;
        pos_next     = pos_reg;
        phase_next   = phase_reg;
        wgd_next     = wgd_reg;
        ticks_next   = ticks_reg;
        taken        = 1'b0;
        if (pop) begin
            if (q_op.action == ACT_OFFER) begin
                // new character, only while idle
                if (!running_reg) begin
                    taken        = 1'b1;
                    running_next = 1'b1;
                    pos_next     = 3'd0;
                    wgd_next     = 1'b0;
                    bits_next    = 5'd0;
                    total_next   = 3'd0;
                    lamp_next    = 1'b0;
                    case (q_op.cls)
                        CLS_SYMBOL: begin
                            bits_next  = q_op.pattern;
                            total_next = q_op.total;
                            phase_next = PH_ON;
                            lamp_next  = 1'b1;
                            ticks_next = q_op.pattern[0] ? u3 : u1;
                        end
                        CLS_SPACE: begin
                            wgd_next   = 1'b1;
                            phase_next = PH_END;
                            ticks_next = u7;
                        end
                        default: begin
                            phase_next = PH_END;
                            ticks_next = u3;
                        end
                    endcase
                end
            end else if (running_reg) begin
                // tick: count down, step the phase when it runs out
                ticks_next = ticks_dec;
                if (ticks_dec == '0) begin
                    case (phase_reg)
                        PH_ON: begin
                            lamp_next  = 1'b0;
                            phase_next = PH_GAP;
                            ticks_next = u1;
                        end
                        PH_GAP: begin
                            pos_next = pos_inc;
                            if (pos_inc < total_reg) begin
                                phase_next = PH_ON;
                                lamp_next  = 1'b1;
                                ticks_next = dash_at_inc ? u3 : u1;
                            end else begin
                                phase_next = PH_END;
                                ticks_next = u3;
                            end
                        end
                        default: begin
                            if (wgd_reg) begin
                                wgd_next   = 1'b0;
                                phase_next = PH_END;
                                ticks_next = u3;
                            end else begin
                                running_next = 1'b0;
                                lamp_next    = 1'b0;
                            end
                        end
                    endcase
                end
            end
        end
    end

    always_comb begin
        m_data_next.lamp_on    = lamp_next;
        m_data_next.busy_res   = running_next;
        m_data_next.char_taken = taken;
    end

    // state, dot-time register and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg     <= DOT_TICKS_RESET;
            running_reg <= 1'b0;
            lamp_reg    <= 1'b0;
            bits_reg    <= 5'd0;
            total_reg   <= 3'd0;
            pos_reg     <= 3'd0;
            phase_reg   <= PH_ON;
            wgd_reg     <= 1'b0;
            ticks_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                dot_reg <= cfg_wr_data;
            end
            running_reg <= running_next;
            lamp_reg    <= lamp_next;
            bits_reg    <= bits_next;
            total_reg   <= total_next;
            pos_reg     <= pos_next;
            phase_reg   <= phase_next;
            wgd_reg     <= wgd_next;
            ticks_reg   <= ticks_next;
            if (pop) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/morse_code_keyer_core.sv =====
// path: an accepted beat is stored in the queue, then the sequencer registers its result
// throughput: one beat per clock while the result side is not stalled, set by the sequencer update in the back end
// a two-entry queue lets the input side keep taking beats while a result waits
// reset (aresetn, synchronous, active low) clears queue, sequencer and output valid,
// and sets the dot time to 100 ticks
module morse_code_keyer_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  mck_pkg::mck_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output mck_pkg::mck_out_t m_data
);
    import mck_pkg::*;

    logic    push;
    mck_op_t push_op;
    logic    q_ready;
    logic    q_valid;
    mck_op_t q_op;
    logic    pop;

    // classify input beats
    mck_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready)
    );

    // decoupling queue
    mck_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .q_ready (q_ready),
        .q_valid (q_valid),
        .q_op    (q_op),
        .pop     (pop)
    );

    // timing sequencer and result register
    mck_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_op        (q_op),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// ===== design/mck_checker.sv =====
// port-level checks for morse_code_keyer_core, bound to the top level
// depends on mck_pkg and morse_code_keyer_core_macros.svh
`include "morse_code_keyer_core_macros.svh"

module mck_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input mck_pkg::mck_out_t m_data
);
    import mck_pkg::*;

    // no result beat right after reset
    `MCK_ASSERT_NXT_RST(a_rst_no_result, !aresetn, !m_valid)

    // a taken character always leaves the keyer busy
    `MCK_ASSERT_IMP(a_taken_busy, m_valid && m_data.char_taken, m_data.busy_res)

    // the lamp is only lit while a character runs
    `MCK_ASSERT_IMP(a_lamp_busy, m_valid && m_data.lamp_on, m_data.busy_res)

    // a stalled result holds
    `MCK_ASSERT_NXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data))

endmodule

bind morse_code_keyer_core mck_checker u_mck_checker (.*);

// ===== dv/morse_code_keyer_core_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for morse_code_keyer_core: directed and random beats, scored
// against a behavioral keyer model kept inside this file; depends on mck_pkg and the core
module morse_code_keyer_core_tb;

    import mck_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RAND_PHASES   = 12;
    localparam int PHASE_BEATS   = 150;

    // keyer phases as the model tracks them
    typedef enum logic [1:0] {
        PH_MARK         = 2'd0,
        PH_SPACE        = 2'd1,
        PH_CHAR_GAP     = 2'd2,
        PH_CHAR_GAP_ALT = 2'd3
    } key_phase_t;

    logic              aclk        = 1'b0;
    logic              aresetn     = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [DOT_W-1:0]  cfg_wr_data = '0;
    logic              s_valid     = 1'b0;
    logic              s_ready;
    mck_in_t           s_data      = '0;
    logic              m_valid;
    logic              m_ready     = 1'b0;
    mck_out_t          m_data;

    // model state
    logic [DOT_W-1:0]  dot_len;
    logic              keying;
    logic              lamp;
    logic [4:0]        dash_map;
    logic [2:0]        elem_count;
    logic [2:0]        elem_idx;
    key_phase_t        phase;
    logic              word_gap_pending;
    logic [TICK_W-1:0] ticks_rem;

    mck_out_t predicted_levels[$];

    // run control shared between processes
    bit tx_idle  = 1'b0;
    bit rx_idle  = 1'b0;
    int hold_req = 0;

    int fail_cnt      = 0;
    int beats_sent    = 0;
    int results_seen  = 0;
    int chars_taken   = 0;
    int offers_dropped = 0;
    int cfg_writes    = 0;

    morse_code_keyer_core uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // ---------------------------------------------------------------- keyer model

    function automatic string morse_of(input logic [7:0] code);
        logic [7:0] up;
        up = (code >= "a" && code <= "z") ? code - ("a" - "A") : code;
        case (up)
            "A": return ".-";
            "B": return "-...";
            "C": return "-.-.";
            "D": return "-..";
            "E": return ".";
            "F": return "..-.";
            "G": return "--.";
            "H": return "....";
            "I": return "..";
            "J": return ".---";
            "K": return "-.-";
            "L": return ".-..";
            "M": return "--";
            "N": return "-.";
            "O": return "---";
            "P": return ".--.";
            "Q": return "--.-";
            "R": return ".-.";
            "S": return "...";
            "T": return "-";
            "U": return "..-";
            "V": return "...-";
            "W": return ".--";
            "X": return "-..-";
            "Y": return "-.--";
            "Z": return "--..";
            "0": return "-----";
            "1": return ".----";
            "2": return "..---";
            "3": return "...--";
            "4": return "....-";
            "5": return ".....";
            "6": return "-....";
            "7": return "--...";
            "8": return "---..";
            "9": return "----.";
            default: return "";
        endcase
    endfunction

    // ticks for n dot units, wrapped to the counter width
    function automatic logic [TICK_W-1:0] units(input int n);
        logic [31:0] prod;
        prod = dot_len * n;
        return prod[TICK_W-1:0];
    endfunction

    function automatic void reset_keyer();
        dot_len          = DOT_TICKS_RESET;
        keying           = 1'b0;
        lamp             = 1'b0;
        dash_map         = '0;
        elem_count       = '0;
        elem_idx         = '0;
        phase            = PH_MARK;
        word_gap_pending = 1'b0;
        ticks_rem        = '0;
    endfunction

    function automatic void load_element();
        phase     = PH_MARK;
        lamp      = 1'b1;
        ticks_rem = units(dash_map[elem_idx] ? 3 : 1);
    endfunction

    function automatic void close_phase();
        case (phase)
            PH_MARK: begin
                lamp      = 1'b0;
                phase     = PH_SPACE;
                ticks_rem = units(1);
            end
            PH_SPACE: begin
                elem_idx = elem_idx + 3'd1;
                if (elem_idx < elem_count) begin
                    load_element();
                end else begin
                    phase     = PH_CHAR_GAP;
                    ticks_rem = units(3);
                end
            end
            default: begin
                // a space runs its long gap first, then the normal end gap
                if (word_gap_pending) begin
                    word_gap_pending = 1'b0;
                    phase            = PH_CHAR_GAP;
                    ticks_rem        = units(3);
                end else begin
                    keying = 1'b0;
                    lamp   = 1'b0;
                end
            end
        endcase
    endfunction

    function automatic bit offer_char(input logic [7:0] code);
        string pat;
        int    i;
        if (keying) return 1'b0;
        pat              = morse_of(code);
        keying           = 1'b1;
        elem_idx         = '0;
        word_gap_pending = 1'b0;
        dash_map         = '0;
        elem_count       = '0;
        lamp             = 1'b0;
        if (pat.len() > 0) begin
            for (i = 0; i < pat.len(); i++) dash_map[i] = (pat[i] == "-");
            elem_count = 3'(pat.len());
            load_element();
        end else if (code == " ") begin
            word_gap_pending = 1'b1;
            phase            = PH_CHAR_GAP;
            ticks_rem        = units(7);
        end else begin
            // unmapped code: only the end gap
            phase     = PH_CHAR_GAP;
            ticks_rem = units(3);
        end
        return 1'b1;
    endfunction

    function automatic mck_out_t advance_keyer(input mck_in_t beat);
        mck_out_t res;
        bit       taken;
        taken = 1'b0;
        if (beat.action == ACT_OFFER) begin
            taken = offer_char(beat.char_code);
            if (taken) chars_taken++;
            else offers_dropped++;
        end else if (keying) begin
            if (ticks_rem != '0) ticks_rem = ticks_rem - 1'b1;
            if (ticks_rem == '0) close_phase();
        end
        res.lamp_on    = lamp;
        res.busy_res   = keying;
        res.char_taken = taken;
        return res;
    endfunction

    // ---------------------------------------------------------------- scoreboard

    function automatic void check_field(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("%s mismatch: expected %0b, actual %0b", name, want, got);
            fail_cnt++;
        end
    endfunction

    // result beats against predictions, then input beats and register writes into the model
    always @(posedge aclk) begin : scoreboard
        mck_out_t want;
        if (!aresetn) begin
            reset_keyer();
            predicted_levels.delete();
        end else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (predicted_levels.size() == 0) begin
                    $error("result beat with nothing predicted: %b", m_data);
                    fail_cnt++;
                end else begin
                    want = predicted_levels.pop_front();
                    check_field("lamp_on", want.lamp_on, m_data.lamp_on);
                    check_field("busy_res", want.busy_res, m_data.busy_res);
                    check_field("char_taken", want.char_taken, m_data.char_taken);
                end
            end
            if (s_valid && s_ready) predicted_levels.push_back(advance_keyer(s_data));
            if (cfg_wr_en) dot_len = cfg_wr_data;
        end
    end

    // ---------------------------------------------------------------- result side

    // random stalls per beat, plus a long hold-off on request
    initial begin : result_sink
        int wait_n;
        @(posedge aclk);
        forever begin
            if (hold_req > 0) begin
                wait_n   = hold_req;
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            wait_n = rx_idle ? $urandom_range(0, 7) : 0;
            if (wait_n > 0) begin
                m_ready <= 1'b0;
                repeat (wait_n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------- stimulus helpers

    // offer one beat and hold it until taken; valid stays up when no gap follows
    task automatic send_beat(input logic act, input logic [7:0] code);
        mck_in_t beat;
        int      gap;
        beat.action    = act;
        beat.char_code = code;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(ACT_TICK, 8'($urandom()));
    endtask

    // stop offering and let every predicted result come back
    task automatic quiesce();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (predicted_levels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_dot_time(input logic [DOT_W-1:0] val);
        quiesce();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return 8'("A" + $urandom_range(0, 25));
        if (r < 55) return 8'("a" + $urandom_range(0, 25));
        if (r < 70) return 8'("0" + $urandom_range(0, 9));
        if (r < 78) return " ";
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [DOT_W-1:0] pick_dot_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 1) return '0;
        if (r < 6) return DOT_W'($urandom_range(1, 2));
        return DOT_W'($urandom_range(3, 6));
    endfunction

    // mostly whole characters ticked out, with some offers while busy
    task automatic send_random_beat();
        bit offer;
        offer = keying ? ($urandom_range(0, 99) < 5) : ($urandom_range(0, 99) < 80);
        if (offer) send_beat(ACT_OFFER, pick_char());
        else send_beat(ACT_TICK, 8'($urandom()));
    endtask

    // ---------------------------------------------------------------- tests

    // ticks at reset leave the idle keyer alone
    task automatic test_idle_ticks();
        send_beat(ACT_TICK, 8'h00);
        send_beat(ACT_TICK, 8'hff);
    endtask

    // zero dot time: each phase ends on the next tick; an offer mid-character is refused
    task automatic test_zero_dot_time();
        write_dot_time('0);
        send_beat(ACT_OFFER, "e");
        send_ticks(1);
        send_beat(ACT_OFFER, "T");
        send_ticks(2);
    endtask

    // unmapped codes at both ends of the range and the word space
    task automatic test_odd_characters();
        send_beat(ACT_OFFER, 8'h00);
        send_ticks(1);
        send_beat(ACT_OFFER, 8'hff);
        send_ticks(1);
        send_beat(ACT_OFFER, " ");
        send_ticks(2);
    endtask

    // five-element digit, all dashes but the last
    task automatic test_digit_sequence();
        send_beat(ACT_OFFER, "9");
        send_ticks(11);
    endtask

    // dot time changed between phases, often in the middle of a character
    task automatic test_random_traffic();
        int ph;
        int n;
        int mode;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            write_dot_time(pick_dot_time());
            mode    = $urandom_range(0, 3);
            tx_idle = (mode & 1) != 0;
            rx_idle = (mode & 2) != 0;
            for (n = 0; n < PHASE_BEATS; n++) send_random_beat();
        end
        quiesce();
    endtask

    // long receiver hold-off while beats keep coming, so the input side backs up
    task automatic test_output_backpressure();
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        hold_req = 120;
        repeat (30) send_random_beat();
        quiesce();
    endtask

    // zero dot time, then largest dot time, longest gap loaded into the tick counter
    task automatic test_dot_extremes();
        write_dot_time('0);
        send_ticks(60);
        write_dot_time({DOT_W{1'b1}});
        send_beat(ACT_OFFER, " ");
        send_ticks(3);
        send_beat(ACT_OFFER, "Q");
        send_ticks(1);
        quiesce();
    endtask

    initial begin : main_seq
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_idle_ticks();
        test_zero_dot_time();
        test_odd_characters();
        test_digit_sequence();
        test_random_traffic();
        test_output_backpressure();
        test_dot_extremes();

        if (predicted_levels.size() != 0) begin
            $error("%0d predicted results never arrived", predicted_levels.size());
            fail_cnt++;
        end
        $display("sent %0d beats: %0d characters keyed, %0d offers refused while busy; %0d results",
                 beats_sent, chars_taken, offers_dropped, results_seen);
        $display("dot time set %0d times from zero to full scale, under gaps, stalls and hold-off",
                 cfg_writes);
        if (fail_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/mck_pkg.sv
design/mck_front.sv
design/mck_queue.sv
design/mck_back.sv
design/morse_code_keyer_core.sv
design/mck_checker.sv
dv/morse_code_keyer_core_tb.sv
